### rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared widths, operation codes and status codes of the byte deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int MODE_W   = 3;
   localparam int DATA_W   = 8;
   localparam int ROT_W    = 16;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] OP_ROTATE     = 3'd4;
   localparam logic [MODE_W-1:0] OP_REVERSE    = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

### rtl/cdq_modulo.sv
// ----------------------------------------------------------------------------
// cdq_modulo
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cdq_modulo #(
   parameter int NUM_W = cdq_pkg::ROT_W,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract back when it fits
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[DEN_W-1:0];
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/cdq_store.sv
// ----------------------------------------------------------------------------
// cdq_store
// Byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cdq_store #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int AW    = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [cdq_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [cdq_pkg::DATA_W-1:0] rd_data
);

   logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];
   logic [cdq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/char_deque_rotate_reverse.sv
// ----------------------------------------------------------------------------
// char_deque_rotate_reverse
// Double-ended byte queue in a circular store with rotate and reverse.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat contents                          | handshake
//   --------+-----------+----------------------------------------+--------------------
//   req_    | in        | mode, data_in, rotate_amount           | req_valid/req_stall
//   rsp_    | out       | data_out, status, item_count           | rsp_valid/rsp_stall
//
// One request beat is handled at a time; req_stall is high from accept until
// the result has been loaded into the output register.
// Steps per beat: push, reverse and unused modes go from execute to done; pops
// add a read state (one memory read with registered data); rotate runs the
// remainder unit, which takes one amount bit per cycle, then k = |amount| mod
// count bytes each take a read step and a write step on the single memory.
// Reset clears head, count, direction and the output valid; store contents
// stay undefined and are never read before being written.
// A stalled result holds in the output register; a finished item waits in
// the done state until the output register frees up.
// ----------------------------------------------------------------------------
module char_deque_rotate_reverse #(
   parameter  int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cdq_pkg::MODE_W-1:0]    req_mode,
   input  logic [cdq_pkg::DATA_W-1:0]    req_data_in,
   input  logic signed [cdq_pkg::ROT_W-1:0] req_rotate_amount,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cdq_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [cdq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [CW-1:0]                 rsp_item_count
);

   localparam int RW = cdq_pkg::ROT_W;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_READ    = 3'd2;
   localparam logic [2:0] S_DIV     = 3'd3;
   localparam logic [2:0] S_MOVE_RD = 3'd4;
   localparam logic [2:0] S_MOVE_WR = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // Physical slot off steps past base in walking direction (rev walks down).
   function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off,
                                             input logic          rev);
      logic [AW:0] sum;
      if (rev) begin
         sum = {1'b0, base} + DEPTH_A - {1'b0, off};
      end else begin
         sum = {1'b0, base} + {1'b0, off};
      end
      if (sum >= DEPTH_A) begin
         sum = sum - DEPTH_A;
      end
      return sum[AW-1:0];
   endfunction

   // control state
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic [CW-1:0] move_left_ff, move_left_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [cdq_pkg::MODE_W-1:0] op_ff, op_in;
   logic [cdq_pkg::DATA_W-1:0] byte_ff, byte_in;
   logic [RW-1:0]              mag_ff, mag_in;
   logic                       neg_ff, neg_in;

   // result being built, and the output register
   logic [cdq_pkg::DATA_W-1:0]   res_data_ff, res_data_in;
   logic [cdq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [cdq_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [cdq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;

   // memory and remainder unit hookup
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [cdq_pkg::DATA_W-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [cdq_pkg::DATA_W-1:0] rd_data;
   logic                       div_start;
   logic                       div_done;
   logic [CW-1:0]              div_rem;

   // neighbor slots of the current head
   logic [CW-1:0] count_m1;
   logic          full;
   logic          empty;
   logic [AW-1:0] fwd1;
   logic [AW-1:0] back1;
   logic [AW-1:0] tail;
   logic [AW-1:0] after_tail;
   logic          req_accept;
   logic          out_free;

   assign count_m1   = count_ff - 1'b1;
   assign full       = (count_ff == DEPTH_C);
   assign empty      = (count_ff == '0);
   assign fwd1       = slot_at(head_ff, AW'(1), rev_ff);
   assign back1      = slot_at(head_ff, AW'(1), ~rev_ff);
   assign tail       = slot_at(head_ff, count_m1[AW-1:0], rev_ff);
   assign after_tail = slot_at(head_ff, count_ff[AW-1:0], rev_ff);

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      move_left_in  = move_left_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      op_in         = op_ff;
      byte_in       = byte_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = byte_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               // capture the beat; fold the signed amount to a magnitude
               op_in         = req_mode;
               byte_in       = req_data_in;
               neg_in        = req_rotate_amount[RW-1];
               mag_in        = req_rotate_amount[RW-1] ?
                               (~req_rotate_amount + 1'b1) : req_rotate_amount;
               res_data_in   = '0;
               res_status_in = cdq_pkg::ST_OK;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff)
               cdq_pkg::OP_PUSH_FRONT: begin
                  if (full) begin
                     res_status_in = cdq_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = back1;
                     head_in  = back1;
                     count_in = count_ff + 1'b1;
                  end
               end
               cdq_pkg::OP_PUSH_BACK: begin
                  if (full) begin
                     res_status_in = cdq_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = after_tail;
                     count_in = count_ff + 1'b1;
                  end
               end
               cdq_pkg::OP_POP_FRONT: begin
                  if (empty) begin
                     res_status_in = cdq_pkg::ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     head_in  = fwd1;
                     count_in = count_m1;
                     state_in = S_READ;
                  end
               end
               cdq_pkg::OP_POP_BACK: begin
                  if (empty) begin
                     res_status_in = cdq_pkg::ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = tail;
                     count_in = count_m1;
                     state_in = S_READ;
                  end
               end
               cdq_pkg::OP_ROTATE: begin
                  // empty queue: nothing to rotate
                  if (!empty) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               cdq_pkg::OP_REVERSE: begin
                  // make the last item the front and walk the other way
                  if (!empty) begin
                     head_in = tail;
                  end
                  rev_in = ~rev_ff;
               end
               default: begin
                  // unused modes: no operation
               end
            endcase
         end
         S_READ: begin
            res_data_in = rd_data;
            state_in    = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               move_left_in = div_rem;
               if (div_rem == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MOVE_RD;
               end
            end
         end
         S_MOVE_RD: begin
            // fetch the front byte (forward) or the back byte (backward)
            rd_en    = 1'b1;
            rd_addr  = neg_ff ? tail : head_ff;
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (neg_ff) begin
               wr_addr = back1;
               head_in = back1;
            end else begin
               wr_addr = after_tail;
               head_in = fwd1;
            end
            move_left_in = move_left_ff - 1'b1;
            if (move_left_ff == CW'(1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MOVE_RD;
            end
         end
         S_DONE: begin
            // hold until the output register is free, then load it
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         move_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         move_left_ff <= move_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   cdq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdq_modulo #(
      .NUM_W (RW),
      .DEN_W (CW)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = rsp_count_ff;

   // count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("item count above depth");

   // a new result appears only out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result without finished item");

   // rotation moves bytes but never changes the count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE_RD || state_ff == S_MOVE_WR) |=> $stable(count_ff))
      else $error("count changed during rotate");

   // every move step has bytes left to move
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE_RD) |-> (move_left_ff != '0))
      else $error("move step with nothing left");

   // memory writes only from execute or a move write
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC || state_ff == S_MOVE_WR))
      else $error("stray memory write");

endmodule
